// ----- hdl/svm_pkg.sv -----
`timescale 1ns / 1ps

package svm_pkg;

    localparam int VOICE_COUNT  = 16;
    localparam int SAMPLE_WORDS = 65536;
    localparam int TANH_ENTRIES = 1024;

    localparam int VW        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int AW        = $clog2(SAMPLE_WORDS);
    localparam int IW        = $clog2(TANH_ENTRIES);
    localparam int TANH_LAST = TANH_ENTRIES - 1;
    // Q45 accumulator with headroom for the largest voice count
    localparam int ACW       = 56;

    localparam logic [15:0] FULL_SCALE = 16'd32768;
    localparam logic [63:0] Q32_ONE    = 64'h1_0000_0000;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_VCHK,
        ST_RDB,
        ST_DIFF,
        ST_INTERP,
        ST_GAIN,
        ST_VOL,
        ST_ACC,
        ST_LCLAMP,
        ST_LSCALE,
        ST_LRDLO,
        ST_LRDHI,
        ST_LMUL,
        ST_LOUT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic latch;
        logic tick_begin;
        logic start_wr;
        logic vchk;
        logic rd_b;
        logic diff;
        logic interp;
        logic gain;
        logic vol;
        logic acc;
        logic next_voice;
        logic lim_clamp;
        logic lim_scale;
        logic rom_lo;
        logic rom_hi;
        logic lim_mul;
        logic tick_out;
    } cmd_t;

    typedef struct packed {
        logic voice_active;
        logic last_voice;
        logic out_free;
    } status_t;

    typedef logic [TANH_ENTRIES-1:0][15:0] tanh_rom_t;

    // restoring long division, only used while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) in Q32, f up to 0.5, truncating Taylor series
    function automatic logic [63:0] exp_neg_small(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = Q32_ONE;
        sum  = $signed(Q32_ONE);
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * f) >> 32, 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return $unsigned(sum);
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] y);
        logic [63:0] half;
        logic [63:0] m;
        logic [63:0] r;
        half = exp_neg_small(64'h8000_0000);
        m    = y >> 31;
        r    = exp_neg_small(y & 64'h7FFF_FFFF);
        for (int j = 0; j < 40; j++) begin
            if (64'(j) < m) begin
                r = (r * half) >> 32;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] tanh_entry(input int k);
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] v;
        y = udiv64(64'(k) << 36, 64'(TANH_LAST));
        e = exp_neg(y);
        if (e > Q32_ONE) begin
            e = Q32_ONE;
        end
        num = Q32_ONE - e;
        den = Q32_ONE + e;
        v   = udiv64(num * 64'd32768 + (den >> 1), den);
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

    function automatic tanh_rom_t build_tanh();
        tanh_rom_t rom;
        for (int k = 0; k < TANH_ENTRIES; k++) begin
            rom[k] = tanh_entry(k);
        end
        return rom;
    endfunction

endpackage

// ----- hdl/sample_voice_mixer.sv -----
`timescale 1ns / 1ps
// Load writes sample memory in idle; Start goes via ST_START to the ack word.
// Tick: ST_VCHK per voice, ST_RDB to ST_ACC per playing voice, ST_LCLAMP to
// ST_LOUT, as the single-port sample memory read and multiply chain need.
// One word at a time; a finished word waits in the output register.
// aresetn (synchronous) clears all voices and sets master volume to 1.0.

module sample_voice_mixer import svm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [15:0]        s_sample_address,
    input  logic signed [15:0] s_sample_value,
    input  logic [15:0]        s_voice_start,
    input  logic [16:0]        s_voice_length,
    input  logic [17:0]        s_pitch_step,
    input  logic [15:0]        s_voice_gain,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic signed [15:0] m_out_sample,
    output logic [3:0]         m_voice_slot,
    output logic               m_dropped
);

    cmd_t    cmd;
    status_t status;

    svm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    svm_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_sample_address (s_sample_address),
        .s_sample_value   (s_sample_value),
        .s_voice_start    (s_voice_start),
        .s_voice_length   (s_voice_length),
        .s_pitch_step     (s_pitch_step),
        .s_voice_gain     (s_voice_gain),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_out_sample     (m_out_sample),
        .m_voice_slot     (m_voice_slot),
        .m_dropped        (m_dropped)
    );

endmodule

// ----- hdl/svm_ctrl.sv -----
`timescale 1ns / 1ps

module svm_ctrl import svm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_action,
    output logic       s_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    action_t act;

    assign act = action_t'(s_action);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (act)
                        ACT_START: state_next = ST_START;
                        ACT_TICK:  state_next = ST_VCHK;
                        ACT_LOAD, ACT_NONE: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START:  if (status.out_free) state_next = ST_IDLE;
            ST_VCHK: begin
                if (status.voice_active) begin
                    state_next = ST_RDB;
                end else if (status.last_voice) begin
                    state_next = ST_LCLAMP;
                end
            end
            ST_RDB:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_VOL;
            ST_VOL:    state_next = ST_ACC;
            ST_ACC:    state_next = status.last_voice ? ST_LCLAMP : ST_VCHK;
            ST_LCLAMP: state_next = ST_LSCALE;
            ST_LSCALE: state_next = ST_LRDLO;
            ST_LRDLO:  state_next = ST_LRDHI;
            ST_LRDHI:  state_next = ST_LMUL;
            ST_LMUL:   state_next = ST_LOUT;
            ST_LOUT:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.latch      = s_valid;
                cmd.load_wr    = s_valid && (act == ACT_LOAD);
                cmd.tick_begin = s_valid && (act == ACT_TICK);
            end
            ST_START:  cmd.start_wr = status.out_free;
            ST_VCHK: begin
                cmd.vchk       = 1'b1;
                cmd.next_voice = !status.voice_active && !status.last_voice;
            end
            ST_RDB:    cmd.rd_b   = 1'b1;
            ST_DIFF:   cmd.diff   = 1'b1;
            ST_INTERP: cmd.interp = 1'b1;
            ST_GAIN:   cmd.gain   = 1'b1;
            ST_VOL:    cmd.vol    = 1'b1;
            ST_ACC: begin
                cmd.acc        = 1'b1;
                cmd.next_voice = !status.last_voice;
            end
            ST_LCLAMP: cmd.lim_clamp = 1'b1;
            ST_LSCALE: cmd.lim_scale = 1'b1;
            ST_LRDLO:  cmd.rom_lo    = 1'b1;
            ST_LRDHI:  cmd.rom_hi    = 1'b1;
            ST_LMUL:   cmd.lim_mul   = 1'b1;
            ST_LOUT:   cmd.tick_out  = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// ----- hdl/svm_datapath.sv -----
`timescale 1ns / 1ps

module svm_datapath import svm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic [15:0]        s_sample_address,
    input  logic signed [15:0] s_sample_value,
    input  logic [15:0]        s_voice_start,
    input  logic [16:0]        s_voice_length,
    input  logic [17:0]        s_pitch_step,
    input  logic [15:0]        s_voice_gain,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic signed [15:0] m_out_sample,
    output logic [3:0]         m_voice_slot,
    output logic               m_dropped
);

    localparam tanh_rom_t TANH_ROM = build_tanh();
    localparam logic signed [ACW-1:0] LIMIT_Q45 = {{(ACW-49){1'b0}}, 1'b1, 48'd0};

    // configuration
    logic [15:0] vol_reg;

    // latched start word
    logic [15:0] in_start_reg;
    logic [16:0] in_len_reg;
    logic [17:0] in_step_reg;
    logic [15:0] in_gain_reg;

    // voice state
    logic [VOICE_COUNT-1:0] busy_reg;
    logic [32:0] pos_reg   [VOICE_COUNT];
    logic [17:0] step_reg  [VOICE_COUNT];
    logic [15:0] gain_reg  [VOICE_COUNT];
    logic [15:0] start_reg [VOICE_COUNT];
    logic [16:0] len_reg   [VOICE_COUNT];
    logic [VW-1:0] vidx_reg;

    // sample memory
    logic signed [15:0] sample_mem [SAMPLE_WORDS];
    logic signed [15:0] mem_q_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      a0_addr;
    logic [AW-1:0]      a1_addr;
    logic [AW+17:0]     addr_sum;
    logic [AW+15:0]     ld_sum;

    // voice arithmetic
    logic signed [15:0] a_reg;
    logic signed [33:0] prod_reg;
    logic signed [15:0] smp_reg;
    logic signed [32:0] gp_reg;
    logic signed [49:0] vp_reg;
    logic signed [ACW-1:0] acc_reg;
    logic signed [16:0] diff;
    logic signed [17:0] smp_sum;

    // limiter
    logic signed [ACW-1:0] clamped;
    logic [ACW-1:0]        mag_full;
    logic [48:0]           mag_reg;
    logic                  neg_reg;
    logic [48+IW:0]        t_reg;
    logic [IW-1:0]         lidx;
    logic                  lsat;
    logic [15:0]           lfrac;
    logic [IW-1:0]         rom_addr;
    logic [15:0]           rom_q_reg;
    logic [15:0]           lo_reg;
    logic [15:0]           dlt;
    logic [31:0]           pm_reg;
    logic [32:0]           pm_round;
    logic [17:0]           lv_sum;
    logic [15:0]           lv;

    // start slot search
    logic          free_found;
    logic [VW-1:0] free_slot;

    // current voice
    logic [32:0] cur_pos;
    logic [16:0] cur_idx;
    logic        retire;

    logic m_valid_reg;

    assign cur_pos = pos_reg[vidx_reg];
    assign cur_idx = cur_pos[32:16];
    assign retire  = ({1'b0, cur_idx} + 18'd1) >= {1'b0, len_reg[vidx_reg]};

    assign status.voice_active = busy_reg[vidx_reg] && !retire;
    assign status.last_voice   = (vidx_reg == VW'(VOICE_COUNT - 1));
    assign status.out_free     = !m_valid_reg || m_ready;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_slot  = VW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg <= FULL_SCALE;
        end else if (cfg_wr_en) begin
            vol_reg <= (cfg_wr_data > FULL_SCALE) ? FULL_SCALE : cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            in_start_reg <= s_voice_start;
            in_len_reg   <= s_voice_length;
            in_step_reg  <= s_pitch_step;
            in_gain_reg  <= (s_voice_gain > FULL_SCALE) ? FULL_SCALE : s_voice_gain;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else begin
            if (cmd.start_wr && free_found) begin
                busy_reg[free_slot] <= 1'b1;
            end
            if (cmd.vchk && busy_reg[vidx_reg] && retire) begin
                busy_reg[vidx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_wr && free_found) begin
            pos_reg[free_slot]   <= '0;
            step_reg[free_slot]  <= in_step_reg;
            gain_reg[free_slot]  <= in_gain_reg;
            start_reg[free_slot] <= in_start_reg;
            len_reg[free_slot]   <= in_len_reg;
        end else if (cmd.vol) begin
            pos_reg[vidx_reg] <= cur_pos + 33'(step_reg[vidx_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vidx_reg <= '0;
        end else if (cmd.tick_begin) begin
            vidx_reg <= '0;
        end else if (cmd.next_voice) begin
            vidx_reg <= vidx_reg + VW'(1);
        end
    end

    // word addresses wrap at the memory size
    assign addr_sum = (AW+18)'(start_reg[vidx_reg]) + (AW+18)'(cur_idx);
    assign a0_addr  = addr_sum[AW-1:0];
    assign a1_addr  = a0_addr + AW'(1);
    assign ld_sum   = (AW+16)'(s_sample_address);
    assign rd_addr  = cmd.rd_b ? a1_addr : a0_addr;

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            sample_mem[ld_sum[AW-1:0]] <= s_sample_value;
        end
        if (cmd.vchk || cmd.rd_b) begin
            mem_q_reg <= sample_mem[rd_addr];
        end
    end

    assign diff    = 17'(mem_q_reg) - 17'(a_reg);
    assign smp_sum = 18'(a_reg) + prod_reg[33:16];

    always_ff @(posedge aclk) begin
        if (cmd.rd_b) begin
            a_reg <= mem_q_reg;
        end
        if (cmd.diff) begin
            prod_reg <= diff * $signed({1'b0, cur_pos[15:0]});
        end
        if (cmd.interp) begin
            smp_reg <= smp_sum[15:0];
        end
        if (cmd.gain) begin
            gp_reg <= smp_reg * $signed({1'b0, gain_reg[vidx_reg]});
        end
        if (cmd.vol) begin
            vp_reg <= gp_reg * $signed({1'b0, vol_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_begin) begin
            acc_reg <= '0;
        end else if (cmd.acc) begin
            acc_reg <= acc_reg + ACW'(vp_reg);
        end
    end

    always_comb begin
        if (acc_reg > LIMIT_Q45) begin
            clamped = LIMIT_Q45;
        end else if (acc_reg < -LIMIT_Q45) begin
            clamped = -LIMIT_Q45;
        end else begin
            clamped = acc_reg;
        end
        mag_full = clamped[ACW-1] ? $unsigned(-clamped) : $unsigned(clamped);
    end

    assign lidx     = t_reg[47+IW:48];
    assign lsat     = lidx >= IW'(TANH_LAST);
    assign lfrac    = t_reg[47:32];
    assign rom_addr = (cmd.rom_hi && !lsat) ? lidx + IW'(1) : lidx;
    assign dlt      = (rom_q_reg >= lo_reg) ? rom_q_reg - lo_reg : 16'd0;
    assign pm_round = 33'(pm_reg) + 33'd32768;
    assign lv_sum   = 18'(lo_reg) + 18'(pm_round[32:16]);

    always_comb begin
        if (lsat) begin
            lv = TANH_ROM[TANH_LAST];
        end else if (lv_sum > 18'd32767) begin
            lv = 16'd32767;
        end else begin
            lv = lv_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lim_clamp) begin
            mag_reg <= mag_full[48:0];
            neg_reg <= acc_reg[ACW-1];
        end
        if (cmd.lim_scale) begin
            t_reg <= (49+IW)'(mag_reg) * (49+IW)'(TANH_LAST);
        end
        if (cmd.rom_lo || cmd.rom_hi) begin
            rom_q_reg <= TANH_ROM[rom_addr];
        end
        if (cmd.rom_hi) begin
            lo_reg <= rom_q_reg;
        end
        if (cmd.lim_mul) begin
            pm_reg <= dlt * lfrac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.start_wr || cmd.tick_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_wr) begin
            m_result_kind <= 1'b1;
            m_out_sample  <= '0;
            m_voice_slot  <= free_found ? 4'(free_slot) : 4'd0;
            m_dropped     <= !free_found;
        end else if (cmd.tick_out) begin
            m_result_kind <= 1'b0;
            m_out_sample  <= neg_reg ? -$signed(lv) : $signed(lv);
            m_voice_slot  <= 4'd0;
            m_dropped     <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hdl/svm_checker.sv -----
`timescale 1ns / 1ps

module svm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_result_kind,
    input logic signed [15:0] m_out_sample,
    input logic [3:0]         m_voice_slot,
    input logic               m_dropped
);

    // a waiting word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample)
            && $stable(m_result_kind) && $stable(m_voice_slot))
        else $error("output word changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_kind |-> m_voice_slot == 4'd0 && !m_dropped)
        else $error("sample word carries slot or drop");

    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind |-> m_out_sample == 16'sd0
            && (!m_dropped || m_voice_slot == 4'd0))
        else $error("malformed start ack");

endmodule

bind sample_voice_mixer svm_checker u_svm_checker (.*);
